FILE: sv/tfsk_pkg.sv
package tfsk_pkg;

	localparam int GROUP_BYTES     = 8;
	localparam int SILENCE_SAMPLES = 24000;
	localparam int LEADER_SAMPLES  = 36000;
	localparam int TAB_MAX         = 18;
	localparam int SILENCE_W       = 15;
	// shortest pattern is 12 samples long, so it sets the widest repeat count
	localparam int LEADER_W        = $clog2(LEADER_SAMPLES / 12 + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SILENCE = 2'd1,
		PH_LEADER  = 2'd2,
		PH_DATA    = 2'd3
	} phase_t;

	typedef enum logic {
		REG_SPEED  = 1'b0,
		REG_INVERT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] speed_mode;
		logic       invert_wave;
	} cfg_t;

	typedef struct packed {
		logic       byte_dropped;
		logic       ready_for_byte;
		logic       sample_valid;
		logic [7:0] sample;
	} result_t;

	localparam logic [7:0] ZERO_TAB [4][TAB_MAX] = '{
		'{8'o226, 8'o300, 8'o342, 8'o370, 8'o377, 8'o370, 8'o342, 8'o300, 8'o226,
		  8'o152, 8'o100, 8'o036, 8'o010, 8'o001, 8'o010, 8'o036, 8'o100, 8'o152},
		'{8'o231, 8'o307, 8'o352, 8'o375, 8'o375, 8'o352, 8'o307, 8'o231, 8'o147,
		  8'o071, 8'o026, 8'o003, 8'o003, 8'o026, 8'o071, 8'o147, 8'h00, 8'h00},
		'{8'o234, 8'o317, 8'o363, 8'o377, 8'o363, 8'o317, 8'o234, 8'o144, 8'o061,
		  8'o015, 8'o001, 8'o015, 8'o061, 8'o144, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'o241, 8'o332, 8'o373, 8'o373, 8'o332, 8'o241, 8'o137, 8'o046, 8'o005,
		  8'o005, 8'o046, 8'o137, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [7:0] ONE_TAB [4][TAB_MAX] = '{
		'{8'o226, 8'o342, 8'o377, 8'o342, 8'o226, 8'o100, 8'o010, 8'o010, 8'o100,
		  8'o226, 8'o342, 8'o377, 8'o342, 8'o226, 8'o100, 8'o010, 8'o010, 8'o100},
		'{8'o261, 8'o366, 8'o366, 8'o261, 8'o117, 8'o012, 8'o012, 8'o117, 8'o261,
		  8'o366, 8'o366, 8'o261, 8'o117, 8'o012, 8'o012, 8'o117, 8'h00, 8'h00},
		'{8'o234, 8'o363, 8'o363, 8'o234, 8'o061, 8'o001, 8'o061, 8'o234, 8'o363,
		  8'o363, 8'o234, 8'o061, 8'o001, 8'o061, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'o300, 8'o377, 8'o300, 8'o100, 8'o001, 8'o100, 8'o300, 8'o377, 8'o300,
		  8'o100, 8'o001, 8'o100, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [4:0] TAB_LEN [4] = '{5'd18, 5'd16, 5'd14, 5'd12};

	localparam logic [LEADER_W-1:0] LEADER_REPS [4] = '{
		LEADER_W'(LEADER_SAMPLES / 18), LEADER_W'(LEADER_SAMPLES / 16),
		LEADER_W'(LEADER_SAMPLES / 14), LEADER_W'(LEADER_SAMPLES / 12)
	};

	localparam logic [7:0] HEADER_MARK [GROUP_BYTES] = '{
		8'o037, 8'o246, 8'o336, 8'o272, 8'o314, 8'o023, 8'o175, 8'o164
	};

	function automatic logic [7:0] pattern_sample(logic [1:0] speed, logic one,
			logic [4:0] pos, logic invert);
		logic [7:0] v;
		v = one ? ONE_TAB[speed][pos] : ZERO_TAB[speed][pos];
		if (invert) begin
			v = 8'(8'd0 - v);
		end
		return v;
	endfunction

endpackage

FILE: sv/tfsk_engine.sv
module tfsk_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              op,
	input  logic [7:0]        data_byte,
	input  logic              end_of_file,
	input  tfsk_pkg::cfg_t    cfg,
	output tfsk_pkg::result_t res
);
	import tfsk_pkg::*;

	logic [7:0]          store_q [GROUP_BYTES];
	logic [3:0]          fill_q;
	logic                ready_q;
	logic                final_q;
	logic                later_q;
	phase_t              phase_q;
	logic [SILENCE_W-1:0] silence_q;
	logic [LEADER_W-1:0] leader_q;
	logic [2:0]          byte_q;
	logic [3:0]          bit_q;
	logic [4:0]          spos_q;

	logic [3:0]          n_fill;
	logic                n_ready;
	logic                n_final;
	logic                n_later;
	phase_t              n_phase;
	logic [SILENCE_W-1:0] n_silence;
	logic [LEADER_W-1:0] n_leader;
	logic [2:0]          n_byte;
	logic [3:0]          n_bit;
	logic [4:0]          n_spos;
	logic                store_we;

	always_comb begin
		logic       is_header;
		logic       finish;
		logic       data_bit;
		logic [4:0] len;
		logic [7:0] cur;
		is_header = (fill_q == 4'd8);
		for (int i = 0; i < GROUP_BYTES; i++) begin
			if (store_q[i] != HEADER_MARK[i]) begin
				is_header = 1'b0;
			end
		end
		finish    = 1'b0;
		data_bit  = 1'b0;
		len       = TAB_LEN[cfg.speed_mode];
		cur       = store_q[byte_q];
		n_fill    = fill_q;
		n_ready   = ready_q;
		n_final   = final_q;
		n_later   = later_q;
		n_phase   = phase_q;
		n_silence = silence_q;
		n_leader  = leader_q;
		n_byte    = byte_q;
		n_bit     = bit_q;
		n_spos    = spos_q;
		store_we  = 1'b0;
		res.sample         = 8'd128;
		res.sample_valid   = 1'b0;
		res.byte_dropped   = 1'b0;
		res.ready_for_byte = 1'b0;

		if (op == OP_LOAD) begin
			if (ready_q || fill_q >= 4'd8) begin
				res.byte_dropped = 1'b1;
			end else begin
				store_we = 1'b1;
				n_fill   = fill_q + 4'd1;
				if (n_fill >= 4'd8 || end_of_file) begin
					n_ready = 1'b1;
					n_final = end_of_file;
				end
			end
		end else begin
			// open a waiting group
			if (phase_q == PH_IDLE && ready_q) begin
				if (is_header) begin
					if (later_q && SILENCE_SAMPLES > 0) begin
						n_phase   = PH_SILENCE;
						n_silence = SILENCE_W'(SILENCE_SAMPLES);
					end else begin
						n_spos = 5'd0;
						if (LEADER_REPS[cfg.speed_mode] == '0) begin
							finish = 1'b1;
						end else begin
							n_phase  = PH_LEADER;
							n_leader = LEADER_REPS[cfg.speed_mode];
						end
					end
				end else begin
					n_phase = PH_DATA;
					n_byte  = 3'd0;
					n_bit   = 4'd0;
					n_spos  = 5'd0;
				end
			end

			if (!finish) begin
				case (n_phase)
					PH_SILENCE: begin
						res.sample_valid = 1'b1;
						if (n_silence != '0) begin
							n_silence = n_silence - SILENCE_W'(1);
						end
						if (n_silence == '0) begin
							n_spos = 5'd0;
							if (LEADER_REPS[cfg.speed_mode] == '0) begin
								finish = 1'b1;
							end else begin
								n_phase  = PH_LEADER;
								n_leader = LEADER_REPS[cfg.speed_mode];
							end
						end
					end
					PH_LEADER: begin
						if (n_spos >= len) begin
							n_spos = 5'd0;
						end
						res.sample = pattern_sample(cfg.speed_mode, 1'b1, n_spos,
							cfg.invert_wave);
						res.sample_valid = 1'b1;
						n_spos = n_spos + 5'd1;
						if (n_spos >= len) begin
							n_spos = 5'd0;
							if (n_leader != '0) begin
								n_leader = n_leader - LEADER_W'(1);
							end
							if (n_leader == '0) begin
								finish = 1'b1;
							end
						end
					end
					PH_DATA: begin
						// start bit, eight data bits LSB first, stop bit
						if (n_bit == 4'd0) begin
							data_bit = 1'b0;
						end else if (n_bit >= 4'd9) begin
							data_bit = 1'b1;
						end else begin
							data_bit = cur[3'(n_bit - 4'd1)];
						end
						if (n_spos >= len) begin
							n_spos = 5'd0;
						end
						res.sample = pattern_sample(cfg.speed_mode, data_bit, n_spos,
							cfg.invert_wave);
						res.sample_valid = 1'b1;
						n_spos = n_spos + 5'd1;
						if (n_spos >= len) begin
							n_spos = 5'd0;
							n_bit  = n_bit + 4'd1;
							if (n_bit > 4'd9) begin
								n_bit = 4'd0;
								if ({1'b0, n_byte} + 4'd1 >= n_fill) begin
									finish = 1'b1;
								end else begin
									n_byte = n_byte + 3'd1;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end

			if (finish) begin
				n_later   = ~final_q;
				n_ready   = 1'b0;
				n_final   = 1'b0;
				n_fill    = 4'd0;
				n_phase   = PH_IDLE;
				n_spos    = 5'd0;
				n_byte    = 3'd0;
				n_bit     = 4'd0;
				n_silence = '0;
				n_leader  = '0;
			end
		end
		res.ready_for_byte = ~n_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 4'd0;
			ready_q   <= 1'b0;
			final_q   <= 1'b0;
			later_q   <= 1'b0;
			phase_q   <= PH_IDLE;
			silence_q <= '0;
			leader_q  <= '0;
			byte_q    <= 3'd0;
			bit_q     <= 4'd0;
			spos_q    <= 5'd0;
		end else if (step) begin
			fill_q    <= n_fill;
			ready_q   <= n_ready;
			final_q   <= n_final;
			later_q   <= n_later;
			phase_q   <= n_phase;
			silence_q <= n_silence;
			leader_q  <= n_leader;
			byte_q    <= n_byte;
			bit_q     <= n_bit;
			spos_q    <= n_spos;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we) begin
			store_q[fill_q[2:0]] <= data_byte;
		end
	end

endmodule

FILE: sv/tape_fsk_sample_generator_unit.sv
// channel | direction | beat contents
// s_axis  | in        | tdata: data_byte; tuser: op; tlast: end_of_file
// m_axis  | out       | tdata: sample, ready_for_byte, byte_dropped; tuser: sample_valid
// cfg     | in        | cfg_index selects speed_mode (0) or invert_wave (1)
//
// One beat in and one beat out per cycle while m_axis is not stalled: a beat lands in
// the input register, the engine handles it there and the result register holds the result.
// The input takes a beat each cycle while m_axis drains.
// Reset clears the group store fill, play state and both config registers.
// A stall on m_axis holds the result and back-pressures through the input register.
module tape_fsk_sample_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] op
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] sample, [8] ready_for_byte, [9] byte_dropped
	output logic        m_axis_tuser,  // [0] sample_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data
);
	import tfsk_pkg::*;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       advance;
	cfg_t       cfg_q;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPEED:  cfg_q.speed_mode  <= cfg_data;
				REG_INVERT: cfg_q.invert_wave <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
			eof_s1  <= s_axis_tlast;
		end
	end

	tfsk_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.op          (op_s1),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.cfg         (cfg_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, res_q.byte_dropped, res_q.ready_for_byte, res_q.sample};
	assign m_axis_tuser  = res_q.sample_valid;

endmodule
